FILE: rtl/time_window_ingress_filter_top_macros.svh
// Assertion helpers for the ingress filter.
`ifndef TIME_WINDOW_INGRESS_FILTER_TOP_MACROS_SVH
`define TIME_WINDOW_INGRESS_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TWIF_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TWIF_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/twif_pkg.sv
package twif_pkg;

  localparam int TIME_W   = 48;
  localparam int BOUND_W  = 40;
  localparam int FRAME_W  = 31;
  localparam int FRAME_OFF = TIME_W - FRAME_W;

  localparam logic [1:0] OP_CHECK     = 2'd0;
  localparam logic [1:0] OP_WR_WINDOW = 2'd1;
  localparam logic [1:0] OP_WR_SAFE   = 2'd2;
  localparam logic [1:0] OP_SET_COUNT = 2'd3;

  localparam logic [1:0] VERDICT_WINDOW = 2'd0;
  localparam logic [1:0] VERDICT_SAFE   = 2'd1;
  localparam logic [1:0] VERDICT_DROP   = 2'd2;

  localparam logic HC_REG = 1'b0;
  localparam logic WC_REG = 1'b1;

  localparam logic [39:0] HC_RESET = 40'd1000000;
  localparam logic [4:0]  WC_RESET = 5'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] now_ns;
    logic [30:0] frame_index;
    logic [3:0]  window_index;
    logic [1:0]  slot_index;
    logic [39:0] start_ns;
    logic [39:0] end_ns;
    logic [2:0]  interval_count;
  } in_item_t;

  typedef struct packed {
    logic       pass;
    logic [1:0] verdict;
  } out_result_t;

endpackage

FILE: rtl/time_window_ingress_filter_top.sv
// Throughput: one transaction per cycle; busy is always low.
// A start passes through the input register, the 48-stage restoring modulo
// pipeline for the time, the registered table read and the result register.
// Reset (synchronous, rst_n low) clears valid bits, interval counts and
// restores hypercycle_ns = 1000000 and window_count = 1; the receiver cannot stall.
`include "time_window_ingress_filter_top_macros.svh"
module time_window_ingress_filter_top
  import twif_pkg::*;
#(
  parameter int WINDOWS         = 16,
  parameter int SAFE_PER_WINDOW = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  in_item_t     in_item,
  output logic         out_valid,
  output out_result_t  out_result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  // Widths derived from the table geometry.
  localparam int WIDX  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int NW    = $clog2(WINDOWS + 1);
  localparam int CNT_W = $clog2(SAFE_PER_WINDOW + 1);
  localparam int STEPS = TIME_W;

  // One pipeline slot: the transaction plus the partial remainders.
  typedef struct packed {
    in_item_t             item;
    logic [BOUND_W-1:0]   rem;
    logic [NW-1:0]        frem;
  } stage_t;

  // Configuration registers, written through the APB-style port.
  logic [BOUND_W-1:0] hc_r;
  logic [4:0]         wc_r;
  logic [NW-1:0]      wdiv;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= HC_RESET;
      wc_r <= WC_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        HC_REG: hc_r <= pwdata[BOUND_W-1:0];
        WC_REG: wc_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      HC_REG: prdata = {24'd0, hc_r};
      WC_REG: prdata = {59'd0, wc_r};
      default: prdata = '0;
    endcase
  end

  // Windows in use: zero counts as one, large counts saturate.
  always_comb begin
    if (wc_r == 5'd0) begin
      wdiv = NW'(1);
    end else if (32'(wc_r) > WINDOWS) begin
      wdiv = NW'(WINDOWS);
    end else begin
      wdiv = NW'(wc_r);
    end
  end

  // One restoring step for the time and, in the last 31 stages, for the
  // frame index. Unless the time divisor is zero, the remainders never reach their divisors.
  function automatic stage_t mod_step(stage_t s, int i, logic [BOUND_W-1:0] d,
                                      logic [NW-1:0] fd);
    stage_t         o;
    logic [BOUND_W:0] x;
    logic [NW:0]      fx;
    o  = s;
    x  = {s.rem, s.item.now_ns[TIME_W-1-i]};
    if (x >= {1'b0, d}) begin
      x = x - {1'b0, d};
    end
    o.rem = x[BOUND_W-1:0];
    if (i >= FRAME_OFF) begin
      fx = {s.frem, s.item.frame_index[TIME_W-1-i]};
      if (fx >= {1'b0, fd}) begin
        fx = fx - {1'b0, fd};
      end
      o.frem = fx[NW-1:0];
    end
    return o;
  endfunction

  stage_t             pipe_r [0:STEPS];
  logic [STEPS:0]     pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[STEPS-1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    pipe_r[0].item <= in_item;
    pipe_r[0].rem  <= '0;
    pipe_r[0].frem <= '0;
    for (int i = 0; i < STEPS; i++) begin
      pipe_r[i+1] <= mod_step(pipe_r[i], i, hc_r, wdiv);
    end
  end

  // Lookup stage. Table writes take effect here, in transaction order, so a
  // check always sees every write that was accepted before it.
  stage_t lk;
  logic [WIDX-1:0] lk_idx;
  logic [WIDX-1:0] lk_widx;
  logic            lk_wok;
  logic [47:0]     lk_t;

  assign lk      = pipe_r[STEPS];
  assign lk_idx  = WIDX'(lk.frem);
  assign lk_widx = WIDX'(lk.item.window_index);
  assign lk_wok  = 32'(lk.item.window_index) < WINDOWS;
  assign lk_t    = (hc_r == '0) ? lk.item.now_ns : {8'd0, lk.rem};

  logic [BOUND_W-1:0] ing_start_mem [0:WINDOWS-1];
  logic [BOUND_W-1:0] ing_end_mem   [0:WINDOWS-1];
  logic [SAFE_PER_WINDOW-1:0][BOUND_W-1:0] safe_start_mem [0:WINDOWS-1];
  logic [SAFE_PER_WINDOW-1:0][BOUND_W-1:0] safe_end_mem   [0:WINDOWS-1];
  logic [CNT_W-1:0]   safe_cnt_r [0:WINDOWS-1];

  logic [CNT_W-1:0]   cnt_sat;
  always_comb begin
    if (32'(lk.item.interval_count) > SAFE_PER_WINDOW) begin
      cnt_sat = CNT_W'(SAFE_PER_WINDOW);
    end else begin
      cnt_sat = CNT_W'(lk.item.interval_count);
    end
  end

  always_ff @(posedge clk) begin
    if (pv_r[STEPS] && lk_wok) begin
      if (lk.item.op == OP_WR_WINDOW) begin
        ing_start_mem[lk_widx] <= lk.item.start_ns;
        ing_end_mem[lk_widx]   <= lk.item.end_ns;
      end
      if (lk.item.op == OP_WR_SAFE && 32'(lk.item.slot_index) < SAFE_PER_WINDOW) begin
        safe_start_mem[lk_widx][lk.item.slot_index] <= lk.item.start_ns;
        safe_end_mem[lk_widx][lk.item.slot_index]   <= lk.item.end_ns;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WINDOWS; w++) begin
        safe_cnt_r[w] <= '0;
      end
    end else if (pv_r[STEPS] && lk_wok && lk.item.op == OP_SET_COUNT) begin
      safe_cnt_r[lk_widx] <= cnt_sat;
    end
  end

  // Registered reads for the compare stage.
  logic               cv_r;
  logic [47:0]        ct_r;
  logic [BOUND_W-1:0] cis_r, cie_r;
  logic [SAFE_PER_WINDOW-1:0][BOUND_W-1:0] css_r, cse_r;
  logic [CNT_W-1:0]   ccnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= pv_r[STEPS] && lk.item.op == OP_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    ct_r   <= lk_t;
    cis_r  <= ing_start_mem[lk_idx];
    cie_r  <= ing_end_mem[lk_idx];
    css_r  <= safe_start_mem[lk_idx];
    cse_r  <= safe_end_mem[lk_idx];
    ccnt_r <= safe_cnt_r[lk_idx];
  end

  // Compare stage: window with 1 ns tolerance, then the counted safe slots.
  logic win_hit, safe_hit;
  always_comb begin
    win_hit = ({1'b0, ct_r} + 49'd1 >= {9'd0, cis_r}) &&
              ({1'b0, ct_r} <= {9'd0, cie_r} + 49'd1);
    safe_hit = 1'b0;
    for (int k = 0; k < SAFE_PER_WINDOW; k++) begin
      if (32'(ccnt_r) > k && ct_r >= {8'd0, css_r[k]} && ct_r < {8'd0, cse_r[k]}) begin
        safe_hit = 1'b1;
      end
    end
  end

  logic        ov_r;
  out_result_t ores_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cv_r;
    end
  end

  always_ff @(posedge clk) begin
    priority if (win_hit) begin
      ores_r <= '{pass: 1'b1, verdict: VERDICT_WINDOW};
    end else if (safe_hit) begin
      ores_r <= '{pass: 1'b1, verdict: VERDICT_SAFE};
    end else begin
      ores_r <= '{pass: 1'b0, verdict: VERDICT_DROP};
    end
  end

  assign out_valid  = ov_r;
  assign out_result = ores_r;

  `TWIF_ASSERT_NEXT(a_strobe_from_check, clk, rst_n, cv_r, out_valid, "check result lost")
  `TWIF_ASSERT_IMPL(a_pass_matches, clk, rst_n, out_valid,
                    out_result.pass == (out_result.verdict != VERDICT_DROP), "pass mismatch")
  `TWIF_ASSERT_NEXT(a_no_spurious, clk, rst_n, !cv_r, !out_valid, "spurious result")
  `TWIF_ASSERT_IMPL(a_frame_rem, clk, rst_n, pv_r[STEPS], lk.frem < wdiv, "frame remainder overflow")

endmodule
